// File: src/imd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types and constants for the interval merge and dedup block.
// ----------------------------------------------------------------------------
package imd_pkg;

    localparam int unsigned MAX_RECORDS_DEF = 64;
    localparam int unsigned RESULT_LIMIT    = 64;
    localparam int unsigned TOP_W           = 7;

    typedef struct packed {
        logic [31:0] s;
        logic [31:0] e;
        logic [2:0]  p;
        logic [11:0] m;
    } t_rec;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_MERGE_RD,
        ST_MERGE_CMP,
        ST_MERGE_FIN,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    // merge order: period, motif, start, end ascending
    function automatic logic before_merge(input t_rec a, input t_rec b);
        logic r;
        if (a.p != b.p)      r = a.p < b.p;
        else if (a.m != b.m) r = a.m < b.m;
        else if (a.s != b.s) r = a.s < b.s;
        else                 r = a.e < b.e;
        return r;
    endfunction

    // select order: start asc, length desc, period asc, motif asc
    function automatic logic before_select(input t_rec a, input t_rec b);
        logic        r;
        logic [31:0] la;
        logic [31:0] lb;
        la = a.e - a.s;
        lb = b.e - b.s;
        if (a.s != b.s)      r = a.s < b.s;
        else if (la != lb)   r = la > lb;
        else if (a.p != b.p) r = a.p < b.p;
        else                 r = a.m < b.m;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/imd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imd_ram
// Record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module imd_ram #(
    parameter int unsigned DEPTH = imd_pkg::MAX_RECORDS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire imd_pkg::t_rec i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output imd_pkg::t_rec      o_rdata
);
    imd_pkg::t_rec r_mem [DEPTH];
    imd_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: src/interval_merge_and_dedup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_merge_and_dedup
// Collects repeat records, merges overlapping same-motif runs, keeps a
// greedy non-overlapping subset and streams the kept records out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one record per transfer, one per cycle
//   while loading. The record with i_last_in closes the set; o_stall then
//   stays high while the set is resolved and emitted.
//   Resolution runs in one record memory with a registered read port:
//   insertion sort (about n*n/2 element shifts worst case), a merge pass,
//   a second insertion sort, a selection pass and emission, which waits
//   on any output stall.
//   Output channel (o_valid / i_stall): a held result stays until a transfer.
//   Records beyond MAX_RECORDS are dropped and flagged on o_overflow.
//   Configuration: i_cfg_valid / o_cfg_ready writes top_count (0 = all).
//   Reset (i_rst_n low, synchronous) empties the set and clears top_count;
//   memory contents are not cleared.
// ----------------------------------------------------------------------------
module interval_merge_and_dedup #(
    parameter int unsigned MAX_RECORDS = imd_pkg::MAX_RECORDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_start_pos,
    input  wire logic [31:0] i_end_pos,
    input  wire logic [2:0]  i_period,
    input  wire logic [11:0] i_motif,
    input  wire logic        i_last_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_out_start,
    output logic [31:0]      o_out_end,
    output logic [2:0]       o_out_period,
    output logic [11:0]      o_out_motif,
    output logic             o_out_last,
    output logic             o_overflow,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data
);
    localparam int unsigned AW = $clog2(MAX_RECORDS);
    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

    imd_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;     // records held
    logic          r_ovf, n_ovf;
    logic [6:0]    r_top;
    logic [CW-1:0] r_i, n_i;         // outer index
    logic [CW-1:0] r_j, n_j;         // inner index / write pointer
    logic [CW-1:0] r_nm, n_nm;       // write count of a pass
    logic          r_sel, n_sel;     // second sort uses select order
    imd_pkg::t_rec r_key, n_key;
    imd_pkg::t_rec r_acc, n_acc;     // merged record under construction
    logic          r_have, n_have;
    logic [CW-1:0] r_lim, n_lim;
    imd_pkg::t_rec r_out, n_out;
    logic          r_ovld, n_ovld;
    logic          r_olast, n_olast;
    logic          r_oovf, n_oovf;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    imd_pkg::t_rec wdata, rdata;

    imd_ram #(.DEPTH(MAX_RECORDS), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    imd_pkg::t_rec in_rec;
    logic          lt;
    logic          in_acc;
    logic          out_acc;
    logic [CW-1:0] kept_lim;
    logic [CW:0]   top_ext;

    assign in_rec  = '{s: i_start_pos, e: i_end_pos, p: i_period, m: i_motif};
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovld && !i_stall;
    assign lt      = r_sel ? imd_pkg::before_select(r_key, rdata)
                           : imd_pkg::before_merge(r_key, rdata);
    assign top_ext = (CW+1)'(r_top);

    always_comb begin
        // limit from kept count r_nm and top_count; RESULT_LIMIT caps it
        kept_lim = r_nm;
        if (r_top != 7'd0 && top_ext < (CW+1)'(r_nm)) kept_lim = CW'(r_top);
        if ((CW+1)'(kept_lim) > (CW+1)'(imd_pkg::RESULT_LIMIT))
            kept_lim = CW'(imd_pkg::RESULT_LIMIT);
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_ovf = r_ovf; n_i = r_i; n_j = r_j; n_nm = r_nm;
        n_sel = r_sel; n_key = r_key; n_acc = r_acc; n_have = r_have;
        n_lim = r_lim; n_out = r_out; n_olast = r_olast; n_oovf = r_oovf;
        n_ovld = r_ovld && i_stall;
        we = 1'b0; waddr = '0; wdata = in_rec; raddr = '0;
        o_stall = 1'b1;
        unique case (r_state)
            imd_pkg::ST_LOAD: begin
                o_stall = 1'b0;
                waddr   = r_cnt[AW-1:0];
                if (in_acc) begin
                    if (r_cnt < CW'(MAX_RECORDS)) begin
                        we    = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_sel   = 1'b0;
                        n_i     = CW'(1);
                        n_state = imd_pkg::ST_SORT_RD;
                    end
                end
            end
            imd_pkg::ST_SORT_RD: begin
                // insertion sort over [0, r_cnt) with key at r_i
                raddr = r_i[AW-1:0];
                if (r_i >= r_cnt) begin
                    if (!r_sel) begin
                        n_i = '0; n_nm = '0; n_have = 1'b0;
                        n_state = imd_pkg::ST_MERGE_RD;
                    end else begin
                        n_i = '0; n_nm = '0; n_have = 1'b0;
                        n_state = imd_pkg::ST_SEL_RD;
                    end
                end else begin
                    n_j     = r_i;
                    n_state = imd_pkg::ST_SORT_CMP;
                end
            end
            imd_pkg::ST_SORT_CMP: begin
                // first visit: rdata is the key; later: rdata is v[j-1]
                if (r_j == r_i && !r_have) begin
                    n_key  = rdata;
                    n_have = 1'b1;
                    raddr  = AW'(r_j - 1'b1);
                end else if (r_have && lt) begin
                    we    = 1'b1;
                    waddr = r_j[AW-1:0];
                    wdata = rdata;
                    n_j   = r_j - 1'b1;
                    raddr = AW'(r_j - 2'd2);
                end
                if (r_have && !lt && !(r_j == r_i && !r_have)) begin
                    we      = 1'b1;
                    waddr   = r_j[AW-1:0];
                    wdata   = r_key;
                    n_have  = 1'b0;
                    n_i     = r_i + 1'b1;
                    n_state = imd_pkg::ST_SORT_RD;
                end
                if (r_have && lt && r_j == CW'(1)) begin
                    n_state = imd_pkg::ST_SORT_CMP;
                    n_have  = 1'b1;
                    n_j     = '0;
                end
                if (r_have && r_j == '0) begin
                    // key reached the front
                    we      = 1'b1;
                    waddr   = '0;
                    wdata   = r_key;
                    n_have  = 1'b0;
                    n_i     = r_i + 1'b1;
                    n_state = imd_pkg::ST_SORT_RD;
                end
            end
            imd_pkg::ST_MERGE_RD: begin
                raddr = r_i[AW-1:0];
                if (r_i >= r_cnt) begin
                    n_state = imd_pkg::ST_MERGE_FIN;
                end else begin
                    n_state = imd_pkg::ST_MERGE_CMP;
                end
            end
            imd_pkg::ST_MERGE_CMP: begin
                // write pointer r_nm never passes r_i, so in-place is safe
                if (r_have && r_acc.p == rdata.p && r_acc.m == rdata.m &&
                    rdata.s <= r_acc.e) begin
                    if (rdata.e > r_acc.e) n_acc.e = rdata.e;
                end else begin
                    if (r_have) begin
                        we    = 1'b1;
                        waddr = AW'(r_nm - 1'b1);
                        wdata = r_acc;
                    end
                    n_acc  = rdata;
                    n_have = 1'b1;
                    n_nm   = r_nm + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = imd_pkg::ST_MERGE_RD;
            end
            imd_pkg::ST_MERGE_FIN: begin
                if (r_have) begin
                    we    = 1'b1;
                    waddr = AW'(r_nm - 1'b1);
                    wdata = r_acc;
                end
                n_cnt   = r_nm;
                n_sel   = 1'b1;
                n_have  = 1'b0;
                n_i     = CW'(1);
                n_state = imd_pkg::ST_SORT_RD;
            end
            imd_pkg::ST_SEL_RD: begin
                raddr = r_i[AW-1:0];
                if (r_i >= r_cnt) begin
                    n_i     = '0;
                    n_state = imd_pkg::ST_EMIT_RD;
                end else begin
                    n_state = imd_pkg::ST_SEL_CMP;
                end
            end
            imd_pkg::ST_SEL_CMP: begin
                if (!r_have || rdata.s >= r_acc.e) begin
                    we     = 1'b1;
                    waddr  = r_nm[AW-1:0];
                    wdata  = rdata;
                    n_acc  = rdata;
                    n_have = 1'b1;
                    n_nm   = r_nm + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = imd_pkg::ST_SEL_RD;
            end
            imd_pkg::ST_EMIT_RD: begin
                raddr = r_i[AW-1:0];
                n_lim = kept_lim;
                if (r_i >= kept_lim) begin
                    n_cnt = '0; n_ovf = 1'b0; n_have = 1'b0;
                    n_state = imd_pkg::ST_LOAD;
                end else if (!r_ovld || !i_stall) begin
                    n_state = imd_pkg::ST_EMIT_OUT;
                end
            end
            imd_pkg::ST_EMIT_OUT: begin
                n_out   = rdata;
                n_olast = (r_i + 1'b1) == r_lim;
                n_oovf  = r_ovf;
                n_ovld  = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = imd_pkg::ST_EMIT_RD;
            end
            default: n_state = imd_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imd_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_top   <= '0;
            r_ovld  <= 1'b0;
            r_have  <= 1'b0;
            r_sel   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_nm    <= '0;
            r_lim   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_ovld  <= n_ovld;
            r_have  <= n_have;
            r_sel   <= n_sel;
            r_i     <= n_i;
            r_j     <= n_j;
            r_nm    <= n_nm;
            r_lim   <= n_lim;
            if (i_cfg_valid && o_cfg_ready) r_top <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_acc   <= n_acc;
        r_out   <= n_out;
        r_olast <= n_olast;
        r_oovf  <= n_oovf;
    end

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_ovld;
    assign o_out_start  = r_out.s;
    assign o_out_end    = r_out.e;
    assign o_out_period = r_out.p;
    assign o_out_motif  = r_out.m;
    assign o_out_last   = r_olast;
    assign o_overflow   = r_oovf;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_RECORDS))
        else $error("record count above capacity");
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_state == imd_pkg::ST_LOAD)
        else $error("record taken outside load");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == imd_pkg::ST_EMIT_OUT |-> !r_ovld || !i_stall)
        else $error("result overwritten while stalled");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> !r_ovld)
        else $error("result repeated after transfer");
endmodule
`default_nettype wire
